@@ rtl/saf_pkg.sv @@
// types, codes and constants shared by the segment allocator modules
package saf_pkg;

   localparam int ADDR_W   = 16;
   localparam int OWNER_W  = 8;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int NFREE_W  = 7;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [ADDR_W-1:0] TOTAL_RESET = 16'd4096;

   localparam logic [FUNC_W-1:0] FUNC_FIRST = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BEST  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOOWNER = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   // register index, taken from paddr[2]
   localparam logic REG_TOTAL_UNITS = 1'b0;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  request_size;
      logic [OWNER_W-1:0] owner_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   grant_address;
      logic [ADDR_W-1:0]   free_total;
      logic [NFREE_W-1:0]  free_segments;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  length;
      logic               is_free;
      logic [OWNER_W-1:0] owner;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_PLAN,
      S_SHIFT,
      S_WRITE_A,
      S_WRITE_B,
      S_COUNT,
      S_COUNT_END,
      S_DONE
   } state_type;

   typedef struct packed {
      logic restart;
      logic accept;
      logic scan_rd;
      logic plan;
      logic shift_rd;
      logic write_a;
      logic write_b;
      logic count_rd;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic rd_last;
      logic shift_left;
      logic rsp_free;
   } sts_type;

endpackage

@@ rtl/saf_ctrl.sv @@
// sequencer for the segment allocator: scan, plan, shift, write, recount
module saf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              restart_pend,
   input  saf_pkg::sts_type  sts,
   output saf_pkg::cmd_type  cmd,
   output logic              req_stall
);
   import saf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!restart_pend && req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.rd_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: state_in = S_PLAN;
         S_PLAN:     state_in = S_SHIFT;
         S_SHIFT: begin
            if (!sts.shift_left) state_in = S_WRITE_A;
         end
         S_WRITE_A: state_in = S_WRITE_B;
         S_WRITE_B: state_in = S_COUNT;
         S_COUNT: begin
            if (sts.rd_last) state_in = S_COUNT_END;
         end
         S_COUNT_END: state_in = S_DONE;
         S_DONE: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall   = restart_pend;
            cmd.restart = restart_pend;
            cmd.accept  = !restart_pend && req_valid;
         end
         S_SCAN:      cmd.scan_rd  = 1'b1;
         S_SCAN_END:  cmd         = '0;
         S_PLAN:      cmd.plan     = 1'b1;
         S_SHIFT:     cmd.shift_rd = sts.shift_left;
         S_WRITE_A:   cmd.write_a  = 1'b1;
         S_WRITE_B:   cmd.write_b  = 1'b1;
         S_COUNT:     cmd.count_rd = 1'b1;
         S_COUNT_END: cmd         = '0;
         S_DONE:      cmd.respond  = sts.rsp_free;
         default:     cmd         = '0;
      endcase
   end

endmodule

@@ rtl/saf_datapath.sv @@
// segment table memory, scan and merge arithmetic, result register
module saf_datapath #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  saf_pkg::cmd_type            cmd,
   input  logic [saf_pkg::ADDR_W-1:0]  total_units,
   input  saf_pkg::req_type            req_data,
   input  logic                        rsp_stall,
   output saf_pkg::sts_type            sts,
   output logic                        rsp_valid,
   output saf_pkg::rsp_type            rsp_data
);
   import saf_pkg::*;

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_TWO = IDX_W'(2);

   entry_type mem [MAX_SEGMENTS];
   entry_type rd_data_ff;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ADDR_W-1:0]   size_ff, size_in;
   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                rd_scan_ff, rd_scan_in;
   logic                rd_shift_ff, rd_shift_in;
   logic                rd_count_ff, rd_count_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]   acc_ff, acc_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic [ADDR_W-1:0]   pick_len_ff, pick_len_in;
   logic [ADDR_W-1:0]   pick_start_ff, pick_start_in;
   logic [ADDR_W-1:0]   last_len_ff, last_len_in;
   logic                last_free_ff, last_free_in;
   logic                next_vld_ff, next_vld_in;
   logic [ADDR_W-1:0]   next_len_ff, next_len_in;
   logic                next_free_ff, next_free_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   grant_ff, grant_in;
   logic                up_ff, up_in;
   logic                two_ff, two_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic                wa_en_ff, wa_en_in;
   logic [IDX_W-1:0]    wa_addr_ff, wa_addr_in;
   entry_type           wa_data_ff, wa_data_in;
   logic                wb_en_ff, wb_en_in;
   logic [IDX_W-1:0]    wb_addr_ff, wb_addr_in;
   entry_type           wb_data_ff, wb_data_in;
   logic [CNT_W-1:0]    used_new_ff, used_new_in;
   logic [ADDR_W-1:0]   ftot_ff, ftot_in;
   logic [CNT_W-1:0]    nfree_ff, nfree_in;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_type             rsp_ff, rsp_in;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;
   logic [IDX_W-1:0]    sh_addr;
   logic                is_alloc;
   logic                split;
   logic                prev_merge;
   logic                next_merge;
   logic [CNT_W-1:0]    pick_cnt;
   logic [CNT_W-1:0]    src_cnt;
   logic [ADDR_W-1:0]   merged_len;

   assign rd_en   = cmd.scan_rd || cmd.shift_rd || cmd.count_rd;
   assign rd_addr = ptr_ff[IDX_W-1:0];
   assign sh_addr = up_ff ? rd_idx_ff + IDX_ONE : rd_idx_ff - (two_ff ? IDX_TWO : IDX_ONE);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      priority if (cmd.restart) begin
         wr_en   = 1'b1;
         wr_data = '{length: total_units, is_free: 1'b1, owner: '0};
      end else if (rd_shift_ff) begin
         wr_en   = 1'b1;
         wr_addr = sh_addr;
         wr_data = rd_data_ff;
      end else if (cmd.write_a) begin
         wr_en   = wa_en_ff;
         wr_addr = wa_addr_ff;
         wr_data = wa_data_ff;
      end else if (cmd.write_b) begin
         wr_en   = wb_en_ff;
         wr_addr = wb_addr_ff;
         wr_data = wb_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign is_alloc   = (func_ff == FUNC_FIRST) || (func_ff == FUNC_BEST);
   assign split      = pick_len_ff > size_ff;
   assign prev_merge = (pick_ff != '0) && last_free_ff;
   assign next_merge = next_vld_ff && next_free_ff;
   assign pick_cnt   = CNT_W'(pick_ff);
   assign src_cnt    = pick_cnt + (next_merge ? CNT_TWO : CNT_ONE);
   assign merged_len = (prev_merge ? last_len_ff : '0) + pick_len_ff
                       + (next_merge ? next_len_ff : '0);

   always_comb begin
      func_in       = func_ff;
      size_in       = size_ff;
      owner_in      = owner_ff;
      used_in       = used_ff;
      ptr_in        = ptr_ff;
      rd_scan_in    = cmd.scan_rd;
      rd_shift_in   = cmd.shift_rd;
      rd_count_in   = cmd.count_rd;
      rd_idx_in     = rd_en ? rd_addr : rd_idx_ff;
      acc_in        = acc_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_len_in   = pick_len_ff;
      pick_start_in = pick_start_ff;
      last_len_in   = last_len_ff;
      last_free_in  = last_free_ff;
      next_vld_in   = next_vld_ff;
      next_len_in   = next_len_ff;
      next_free_in  = next_free_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      up_in         = up_ff;
      two_in        = two_ff;
      rem_in        = rem_ff;
      wa_en_in      = wa_en_ff;
      wa_addr_in    = wa_addr_ff;
      wa_data_in    = wa_data_ff;
      wb_en_in      = wb_en_ff;
      wb_addr_in    = wb_addr_ff;
      wb_data_in    = wb_data_ff;
      used_new_in   = used_new_ff;
      ftot_in       = ftot_ff;
      nfree_in      = nfree_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_in        = rsp_ff;

      if (cmd.restart) used_in = CNT_ONE;

      if (cmd.accept) begin
         func_in      = req_data.func;
         size_in      = req_data.request_size;
         owner_in     = req_data.owner_id;
         ptr_in       = '0;
         acc_in       = '0;
         found_in     = 1'b0;
         last_free_in = 1'b0;
         next_vld_in  = 1'b0;
      end

      if (cmd.scan_rd || cmd.count_rd) ptr_in = ptr_ff + CNT_ONE;

      // scan: starts follow as a running sum of the lengths
      if (rd_scan_ff) begin
         acc_in = acc_ff + rd_data_ff.length;
         if (is_alloc) begin
            if (rd_data_ff.is_free && rd_data_ff.length >= size_ff &&
                (!found_ff || (func_ff == FUNC_BEST && rd_data_ff.length < pick_len_ff))) begin
               found_in      = 1'b1;
               pick_in       = rd_idx_ff;
               pick_len_in   = rd_data_ff.length;
               pick_start_in = acc_ff;
            end
         end else if (func_ff == FUNC_FREE) begin
            if (!found_ff && !rd_data_ff.is_free && rd_data_ff.owner == owner_ff) begin
               found_in    = 1'b1;
               pick_in     = rd_idx_ff;
               pick_len_in = rd_data_ff.length;
            end else if (found_ff && !next_vld_ff) begin
               next_vld_in  = 1'b1;
               next_len_in  = rd_data_ff.length;
               next_free_in = rd_data_ff.is_free;
            end else if (!found_ff) begin
               last_len_in  = rd_data_ff.length;
               last_free_in = rd_data_ff.is_free;
            end
         end
      end

      if (cmd.plan) begin
         status_in   = ST_OK;
         grant_in    = '0;
         wa_en_in    = 1'b0;
         wa_addr_in  = pick_ff + IDX_ONE;
         wa_data_in  = '{length: pick_len_ff - size_ff, is_free: 1'b1, owner: '0};
         wb_en_in    = 1'b0;
         wb_addr_in  = pick_ff;
         wb_data_in  = '{length: size_ff, is_free: 1'b0, owner: owner_ff};
         used_new_in = used_ff;
         up_in       = 1'b0;
         two_in      = 1'b0;
         rem_in      = '0;
         if (is_alloc) begin
            if (size_ff == '0) begin
               status_in = ST_ZERO;
            end else if (!found_ff) begin
               status_in = ST_NOFIT;
            end else if (split && used_ff >= CNT_MAX) begin
               status_in = ST_FULL;
            end else begin
               grant_in = pick_start_ff;
               wb_en_in = 1'b1;
               if (split) begin
                  // open a slot after the pick for the remainder
                  wa_en_in    = 1'b1;
                  used_new_in = used_ff + CNT_ONE;
                  up_in       = 1'b1;
                  ptr_in      = used_ff - CNT_ONE;
                  rem_in      = used_ff - CNT_ONE - pick_cnt;
               end
            end
         end else if (func_ff == FUNC_FREE) begin
            if (!found_ff) begin
               status_in = ST_NOOWNER;
            end else begin
               wb_en_in   = 1'b1;
               wb_addr_in = prev_merge ? pick_ff - IDX_ONE : pick_ff;
               wb_data_in = '{length: merged_len, is_free: 1'b1, owner: '0};
               if (prev_merge || next_merge) begin
                  // close the gap left by the absorbed neighbours
                  two_in      = prev_merge && next_merge;
                  used_new_in = used_ff - ((prev_merge && next_merge) ? CNT_TWO : CNT_ONE);
                  ptr_in      = src_cnt;
                  rem_in      = used_ff - src_cnt;
               end
            end
         end
      end

      if (cmd.shift_rd) begin
         rem_in = rem_ff - CNT_ONE;
         ptr_in = up_ff ? ptr_ff - CNT_ONE : ptr_ff + CNT_ONE;
      end

      if (cmd.write_b) begin
         used_in  = used_new_ff;
         ptr_in   = '0;
         ftot_in  = '0;
         nfree_in = '0;
      end

      if (rd_count_ff && rd_data_ff.is_free) begin
         ftot_in  = ftot_ff + rd_data_ff.length;
         nfree_in = nfree_ff + CNT_ONE;
      end

      if (cmd.respond) begin
         rsp_vld_in = 1'b1;
         rsp_in     = '{status: status_ff, grant_address: grant_ff,
                        free_total: ftot_ff, free_segments: NFREE_W'(nfree_ff)};
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= CNT_ONE;
         rd_scan_ff  <= 1'b0;
         rd_shift_ff <= 1'b0;
         rd_count_ff <= 1'b0;
         found_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         used_ff     <= used_in;
         rd_scan_ff  <= rd_scan_in;
         rd_shift_ff <= rd_shift_in;
         rd_count_ff <= rd_count_in;
         found_ff    <= found_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      size_ff       <= size_in;
      owner_ff      <= owner_in;
      ptr_ff        <= ptr_in;
      rd_idx_ff     <= rd_idx_in;
      acc_ff        <= acc_in;
      pick_ff       <= pick_in;
      pick_len_ff   <= pick_len_in;
      pick_start_ff <= pick_start_in;
      last_len_ff   <= last_len_in;
      last_free_ff  <= last_free_in;
      next_vld_ff   <= next_vld_in;
      next_len_ff   <= next_len_in;
      next_free_ff  <= next_free_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      up_ff         <= up_in;
      two_ff        <= two_in;
      rem_ff        <= rem_in;
      wa_en_ff      <= wa_en_in;
      wa_addr_ff    <= wa_addr_in;
      wa_data_ff    <= wa_data_in;
      wb_en_ff      <= wb_en_in;
      wb_addr_ff    <= wb_addr_in;
      wb_data_ff    <= wb_data_in;
      used_new_ff   <= used_new_in;
      ftot_ff       <= ftot_in;
      nfree_ff      <= nfree_in;
      rsp_ff        <= rsp_in;
   end

   assign sts.rd_last    = ptr_ff == (used_ff - CNT_ONE);
   assign sts.shift_left = rem_ff != '0;
   assign sts.rsp_free   = !rsp_vld_ff || !rsp_stall;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_data       = rsp_ff;

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff != '0 && used_ff <= CNT_MAX)
      else $error("segment count out of range");

   a_split_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_a && wa_en_ff) |-> used_ff < CNT_MAX)
      else $error("split written into a full table");

   a_shift_target: assert property (@(posedge clock) disable iff (reset)
      rd_shift_ff |-> CNT_W'(sh_addr) < used_new_ff)
      else $error("shifted entry lands beyond the table");

endmodule

@@ rtl/segment_allocator_fit.sv @@
// segment allocator: first fit / best fit with coalescing of free neighbours
//
// req channel: one request item per accept (func, request_size, owner_id),
// taken when req_valid is high and req_stall is low. rsp channel: one
// result item per request (status, grant_address, free_total,
// free_segments), held while rsp_stall is high.
// Each request reads the whole table once to choose a segment, moves the
// entries behind a split or a merge one a cycle, writes up to two entries
// and reads the table again to count free space. Items are handled one at
// a time; the next request is taken while a result still waits on a
// stalled rsp channel, and is finished up to the result register before
// it waits too.
// Reset sets total_units to 4096 and leaves a restart pending, after which
// the table holds a single free segment. A write of total_units over the
// APB port restarts the map the same way, stalling req while it is pending.
module segment_allocator_fit #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  saf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output saf_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [saf_pkg::PADDR_W-1:0]   paddr,
   input  logic [saf_pkg::PDATA_W-1:0]   pwdata,
   output logic [saf_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import saf_pkg::*;

   logic [ADDR_W-1:0] total_ff, total_in;
   logic              pend_ff, pend_in;
   logic              csr_write;
   cmd_type           cmd;
   sts_type           sts;

   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_TOTAL_UNITS);

   always_comb begin
      total_in = total_ff;
      pend_in  = pend_ff;
      if (csr_write) begin
         total_in = pwdata[ADDR_W-1:0];
         pend_in  = 1'b1;
      end else if (cmd.restart) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         pend_ff  <= 1'b1;
      end else begin
         total_ff <= total_in;
         pend_ff  <= pend_in;
      end
   end

   assign prdata = (paddr[2] == REG_TOTAL_UNITS) ? PDATA_W'(total_ff) : '0;
   assign pready = 1'b1;

   saf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .restart_pend (pend_ff),
      .sts          (sts),
      .cmd          (cmd),
      .req_stall    (req_stall)
   );

   saf_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .total_units  (total_ff),
      .req_data     (req_data),
      .rsp_stall    (rsp_stall),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule
